[rtl/core/bimo_pkg.sv]
// shared types and constants for the base (i-1) converter
package bimo_pkg;

    localparam int unsigned OUT_DATA_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_READ,
        ST_EMIT,
        ST_ZERO
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic ptr_init;
        logic rd;
        logic ptr_dec;
    } cmd_t;

    typedef struct packed {
        logic in_zero;
        logic rem_zero;
        logic cnt_full;
        logic ptr_zero;
    } sts_t;

endpackage

[rtl/core/bimo_dp.sv]
// datapath: remainder registers, digit store, digit counter and read pointer
module bimo_dp
    import bimo_pkg::*;
#(
    parameter int unsigned PART_BITS  = 20,
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PART_BITS-1:0] real_part,
    input  logic [PART_BITS-1:0] imag_part,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 digit
);

    localparam int unsigned REM_W  = PART_BITS + 2;
    localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);

    logic signed [REM_W-1:0] rem_real_reg, rem_real_next;
    logic signed [REM_W-1:0] rem_imag_reg, rem_imag_next;
    logic        [CNT_W-1:0] cnt_reg, cnt_next;
    logic        [ADDR_W-1:0] ptr_reg, ptr_next;
    logic                     rd_data_reg;
    logic                     digit_store [MAX_DIGITS];

    logic                     cur_digit;
    logic signed [REM_W:0]    diff;
    logic signed [REM_W:0]    half;
    logic signed [REM_W-1:0]  new_imag;
    logic        [CNT_W-1:0]  cnt_less;

    // one digit of the division by (i-1)
    always_comb
    begin
        cur_digit = rem_real_reg[0] ^ rem_imag_reg[0];
        diff      = $signed({{REM_W{1'b0}}, cur_digit})
                    - {rem_real_reg[REM_W-1], rem_real_reg}
                    - {rem_imag_reg[REM_W-1], rem_imag_reg};
        half      = diff >>> 1;
        new_imag  = half[REM_W-1:0];
        cnt_less  = cnt_reg - CNT_W'(1);
    end

    always_comb
    begin
        rem_real_next = rem_real_reg;
        rem_imag_next = rem_imag_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        if (cmd.load)
        begin
            rem_real_next = REM_W'($signed(real_part));
            rem_imag_next = REM_W'($signed(imag_part));
            cnt_next      = '0;
        end
        else if (cmd.step)
        begin
            rem_imag_next = new_imag;
            rem_real_next = rem_imag_reg + new_imag;
            cnt_next      = cnt_reg + CNT_W'(1);
        end
        if (cmd.ptr_init)
        begin
            ptr_next = cnt_less[ADDR_W-1:0];
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_real_reg <= '0;
            rem_imag_reg <= '0;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
        end
        else
        begin
            rem_real_reg <= rem_real_next;
            rem_imag_reg <= rem_imag_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
        end
    end

    // digit store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            digit_store[cnt_reg[ADDR_W-1:0]] <= cur_digit;
        end
        if (cmd.load)
        begin
            rd_data_reg <= 1'b0;
        end
        else if (cmd.rd)
        begin
            rd_data_reg <= digit_store[ptr_reg];
        end
    end

    always_comb
    begin
        sts.in_zero  = (real_part == '0) && (imag_part == '0);
        sts.rem_zero = (rem_real_reg == '0) && (rem_imag_reg == '0);
        sts.cnt_full = (cnt_reg == CNT_W'(MAX_DIGITS));
        sts.ptr_zero = (ptr_reg == '0);
        digit        = rd_data_reg;
    end

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("digit count did not advance on a step");

    a_no_step_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !sts.cnt_full)
        else $error("step issued with a full digit store");

    a_ptr_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ptr_dec |-> !sts.ptr_zero)
        else $error("read pointer decremented below zero");

endmodule

[rtl/core/bimo_ctrl.sv]
// controller state machine: conversion loop and digit emission
module bimo_ctrl
    import bimo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast,
    output logic m_tuser,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        m_tuser    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_zero ? ST_ZERO : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.rem_zero || sts.cnt_full)
                begin
                    cmd.ptr_init = 1'b1;
                    state_next   = ST_READ;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tlast  = sts.ptr_zero;
                if (m_tready)
                begin
                    if (sts.ptr_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_dec = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_ZERO:
            begin
                m_tvalid = 1'b1;
                m_tlast  = 1'b1;
                m_tuser  = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tuser |-> m_tlast)
        else $error("empty transaction without last");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.ptr_init, cmd.rd, cmd.ptr_dec}))
        else $error("more than one datapath command");

endmodule

[rtl/core/base_i_minus_one_converter.sv]
// top level: Gaussian integer to complex base (i-1) digit stream
//
// input channel s_*: one transaction carries a Gaussian integer, real part in
// the low PART_BITS of s_tdata, imaginary part above it, both two's complement
// output channel m_*: one transaction per base (i-1) digit, most significant
// first; m_tlast marks the least significant digit, m_tuser marks the single
// result given for a zero input (digit 0, tlast 1)
// one number is worked at a time: s_tready is high only while idle
// the conversion loop yields one digit per cycle, then each digit is emitted in
// two steps (store read, then output) since the digit store read is registered
// up to MAX_DIGITS digits, lower digits kept; a zero input skips the loop and
// goes straight to the single zero result
// reset returns the controller to idle and clears remainder and counters
// while m_tready is low the current digit holds on m_tdata and the block waits
module base_i_minus_one_converter
    import bimo_pkg::*;
#(
    parameter int unsigned PART_BITS  = 20,
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*PART_BITS+7)/8)*8-1:0]       s_tdata,  // real_part, imag_part
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [OUT_DATA_W-1:0]                  m_tdata,  // digit
    output logic                                   m_tlast,
    output logic                                   m_tuser   // empty_res
);

    cmd_t cmd;
    sts_t sts;
    logic digit;

    bimo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    bimo_dp #(
        .PART_BITS  (PART_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .real_part (s_tdata[PART_BITS-1:0]),
        .imag_part (s_tdata[2*PART_BITS-1:PART_BITS]),
        .cmd       (cmd),
        .sts       (sts),
        .digit     (digit)
    );

    assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, digit};

endmodule

[tb/tb_base_i_minus_one_converter.sv]
// self-checking testbench for the Gaussian integer to base (i-1) converter
module tb_base_i_minus_one_converter;
    import bimo_pkg::*;

    localparam int unsigned PART_W    = 20;
    localparam int unsigned MAX_DIG   = 64;
    localparam int unsigned IN_W      = ((2*PART_W+7)/8)*8;
    localparam int unsigned RAND_ITEMS = 310;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam logic signed [PART_W-1:0] PART_MAX = {1'b0, {(PART_W-1){1'b1}}};
    localparam logic signed [PART_W-1:0] PART_MIN = {1'b1, {(PART_W-1){1'b0}}};

    typedef struct {
        logic signed [PART_W-1:0] re;
        logic signed [PART_W-1:0] im;
        bit                       wait_idle;
    } gauss_item_t;

    typedef struct packed {
        logic digit;
        logic last;
        logic empty_res;
    } digit_exp_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    gauss_item_t   numbers_to_send[$];
    digit_exp_t    digits_due[$];
    int unsigned   src_gap;
    int unsigned   src_quiet;
    int unsigned   sink_wait;
    int unsigned   sink_quiet;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;

    base_i_minus_one_converter #(
        .PART_BITS  (PART_W),
        .MAX_DIGITS (MAX_DIG)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // expected digits, most significant first, from repeated division by (i-1)
    function automatic void predict_digits(input logic signed [PART_W-1:0] re,
                                           input logic signed [PART_W-1:0] im);
        longint a;
        longint b;
        longint d;
        longint ni;
        bit     lsd_first[$];
        a = re;
        b = im;
        if (a == 0 && b == 0)
        begin
            digits_due.push_back('{digit: 1'b0, last: 1'b1, empty_res: 1'b1});
            return;
        end
        while ((a != 0 || b != 0) && lsd_first.size() < MAX_DIG)
        begin
            d  = (a ^ b) & 1;
            ni = (d - a - b) / 2;
            lsd_first.push_back(d[0]);
            a = b + ni;
            b = ni;
        end
        for (int k = lsd_first.size() - 1; k >= 0; k--)
            digits_due.push_back('{digit: lsd_first[k], last: (k == 0), empty_res: 1'b0});
    endfunction

    function automatic int unsigned draw_gap(inout int unsigned quiet_left);
        if (quiet_left != 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            quiet_left = $urandom_range(8, 20);
        return $urandom_range(0, 4);
    endfunction

    function automatic logic signed [PART_W-1:0] pick_part();
        logic signed [PART_W-1:0] v;
        int                       s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = PART_W'($urandom());
            4, 5, 6:
            begin
                s = $urandom_range(0, 127);
                v = PART_W'(s - 64);
            end
            7:       v = '0;
            8:       v = PART_W'(PART_MAX - $urandom_range(0, 15));
            default: v = PART_W'(PART_MIN + $urandom_range(0, 15));
        endcase
        return v;
    endfunction

    task automatic add_number(input logic signed [PART_W-1:0] re,
                              input logic signed [PART_W-1:0] im,
                              input bit wait_idle);
        numbers_to_send.push_back('{re: re, im: im, wait_idle: wait_idle});
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            src_gap   <= 0;
            src_quiet <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap != 0)
            begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end
            else if (numbers_to_send.size() != 0 &&
                     !(numbers_to_send[0].wait_idle && (s_tvalid || digits_due.size() != 0)))
            begin
                s_tdata  <= {{(IN_W-2*PART_W){1'b0}}, numbers_to_send[0].im,
                             numbers_to_send[0].re};
                s_tvalid <= 1'b1;
                void'(numbers_to_send.pop_front());
                src_gap  <= draw_gap(src_quiet);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // sink side
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned w;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_wait  <= 0;
            sink_quiet <= 0;
        end
        else if (m_tready)
        begin
            if (m_tvalid)
            begin
                w = draw_gap(sink_quiet);
                if (w != 0)
                begin
                    m_tready  <= 1'b0;
                    sink_wait <= w - 1;
                end
            end
        end
        else if (sink_wait == 0)
            m_tready <= 1'b1;
        else
            sink_wait <= sink_wait - 1;
    end

    // transaction monitor and checker
    always @(posedge clk)
    begin
        digit_exp_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_digits(s_tdata[PART_W-1:0], s_tdata[2*PART_W-1:PART_W]);
            if (m_tvalid && m_tready)
            begin
                if (digits_due.size() == 0)
                begin
                    $error("unexpected digit transaction: digit %0d last %0d empty_res %0d",
                           m_tdata[0], m_tlast, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = digits_due.pop_front();
                    if (m_tdata[0] !== want.digit)
                    begin
                        $error("digit: expected %0d, got %0d", want.digit, m_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.empty_res)
                    begin
                        $error("empty_res: expected %0d, got %0d", want.empty_res, m_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        logic signed [PART_W-1:0] re;
        logic signed [PART_W-1:0] im;

        // zero, units, axes and corner values
        add_number(0, 0, 1'b0);
        add_number(1, 0, 1'b0);
        add_number(0, 1, 1'b0);
        add_number(-1, 0, 1'b0);
        add_number(0, -1, 1'b0);
        add_number(1, 1, 1'b0);
        add_number(-1, -1, 1'b0);
        add_number(1, -1, 1'b0);
        add_number(-1, 1, 1'b0);
        add_number(2, 0, 1'b0);
        add_number(0, 0, 1'b0);
        add_number(3, -5, 1'b0);
        add_number(PART_MAX, 0, 1'b0);
        add_number(PART_MIN, 0, 1'b0);
        add_number(0, PART_MAX, 1'b0);
        add_number(0, PART_MIN, 1'b0);
        add_number(PART_MAX, PART_MAX, 1'b0);
        add_number(PART_MIN, PART_MIN, 1'b0);
        add_number(PART_MAX, PART_MIN, 1'b0);
        add_number(PART_MIN, PART_MAX, 1'b0);
        add_number(PART_MIN, 1, 1'b0);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if ($urandom_range(0, 14) == 0)
            begin
                re = '0;
                im = '0;
            end
            else
            begin
                re = pick_part();
                im = pick_part();
            end
            add_number(re, im, (n % 80) == 0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_to_send.size() != 0 || s_tvalid || digits_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bimo_pkg.sv
rtl/core/bimo_dp.sv
rtl/core/bimo_ctrl.sv
rtl/core/base_i_minus_one_converter.sv
tb/tb_base_i_minus_one_converter.sv
